[rtl/ssr_pkg.sv]
// Shared types, constants and helper functions for the streaming substring replacer.
package ssr_pkg;

    // Window and replacement geometry.
    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int WIN_IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W           = 4;
    localparam int CNT_W           = 16;

    // Command queue between the front and back parts; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 3'd0,
        CFG_PATTERN_LENGTH     = 3'd1,
        CFG_REPLACEMENT_BYTES  = 3'd2,
        CFG_REPLACEMENT_LENGTH = 3'd3
    } t_cfg_idx;

    typedef logic [MAX_PATTERN-1:0][7:0] t_window;

    // Input request.
    typedef struct packed {
        logic [7:0] char_in;
        logic       char_present;
        logic       string_end;
    } t_in_req;

    // Output request.
    typedef struct packed {
        logic [7:0]       char_out;
        logic             char_valid;
        logic             string_done;
        logic [CNT_W-1:0] match_total;
    } t_out_req;

    // Configuration register file contents.
    typedef struct packed {
        t_window          pattern_bytes;
        logic [LEN_W-1:0] pattern_length;
        t_window          replacement_bytes;
        logic [LEN_W-1:0] replacement_length;
    } t_cfg;

    // One classified item: the list of results it causes, in compact form.
    typedef struct packed {
        logic             hit;        // head bytes come from the replacement
        logic [7:0]       pop_byte;   // head byte when a full window does not match
        logic [LEN_W-1:0] head_cnt;   // replacement length, 1 for a pop, else 0
        t_window          flush;      // bytes flushed at end of string
        logic [LEN_W-1:0] real_cnt;   // head_cnt plus flushed byte count
        logic             last;       // item ends the string
        logic [CNT_W-1:0] total;      // match count reported at end of string
    } t_cmd;

    // Pattern length in use: zero means one, long values saturate.
    function automatic logic [LEN_W-1:0] eff_pattern_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        n = len;
        if (n == '0) begin
            n = LEN_W'(1);
        end else if (n > LEN_W'(MAX_PATTERN)) begin
            n = LEN_W'(MAX_PATTERN);
        end
        return n;
    endfunction

    // Replacement length in use: long values saturate.
    function automatic logic [LEN_W-1:0] eff_repl_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        n = len;
        if (n > LEN_W'(MAX_REPLACEMENT)) begin
            n = LEN_W'(MAX_REPLACEMENT);
        end
        return n;
    endfunction

endpackage

[rtl/ssr_front.sv]
// Front part: byte window, parallel pattern compare and classification of each item.
module ssr_front import ssr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_in_req i_req,
    input  t_cfg    i_cfg,
    output logic    o_cmd_push,
    output t_cmd    o_cmd,
    output logic    o_window_empty
);

    t_window          r_window;
    logic [LEN_W-1:0] r_fill;
    logic [CNT_W-1:0] r_count;

    t_window          n_window;
    logic [LEN_W-1:0] n_fill;
    logic [CNT_W-1:0] n_count;

    t_window          w_ins;
    t_window          w_after;
    logic [LEN_W-1:0] fill_ins;
    logic [LEN_W-1:0] fill_after;
    logic [CNT_W-1:0] count_after;
    logic [LEN_W-1:0] pat_len;
    logic             win_full;
    logic             hit;
    logic             pop;

    // Insert the new byte, compare the window and decide hit, pop or hold.
    always_comb begin
        pat_len  = eff_pattern_len(i_cfg.pattern_length);
        w_ins    = r_window;
        fill_ins = r_fill;
        if (i_req.char_present && (r_fill < LEN_W'(MAX_PATTERN))) begin
            w_ins[r_fill[WIN_IDX_W-1:0]] = i_req.char_in;
            fill_ins = r_fill + 1'b1;
        end
        win_full = i_req.char_present && (fill_ins >= pat_len);

        hit = win_full;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if ((LEN_W'(k) < pat_len) && (w_ins[k] != i_cfg.pattern_bytes[k])) begin
                hit = 1'b0;
            end
        end
        pop = win_full && !hit;

        w_after     = w_ins;
        fill_after  = fill_ins;
        count_after = r_count;
        if (hit) begin
            w_after     = '0;
            fill_after  = '0;
            count_after = (r_count == '1) ? r_count : r_count + 1'b1;
        end else if (pop) begin
            w_after    = {8'h00, w_ins[MAX_PATTERN-1:1]};
            fill_after = fill_ins - 1'b1;
        end
    end

    // Build the command for the back part. An item that causes no result and does
    // not end the string, such as a match that is deleted, sends no command.
    always_comb begin
        o_cmd.hit      = hit;
        o_cmd.pop_byte = w_ins[0];
        o_cmd.head_cnt = hit ? eff_repl_len(i_cfg.replacement_length) : LEN_W'(pop);
        o_cmd.flush    = i_req.string_end ? w_after : '0;
        o_cmd.real_cnt = o_cmd.head_cnt + (i_req.string_end ? fill_after : '0);
        o_cmd.last     = i_req.string_end;
        o_cmd.total    = count_after;
        o_cmd_push     = i_accept && ((o_cmd.real_cnt != '0) || i_req.string_end);
    end

    // End of string empties the window and restarts the count.
    always_comb begin
        n_window = r_window;
        n_fill   = r_fill;
        n_count  = r_count;
        if (i_accept) begin
            if (i_req.string_end) begin
                n_window = '0;
                n_fill   = '0;
                n_count  = '0;
            end else begin
                n_window = w_after;
                n_fill   = fill_after;
                n_count  = count_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_fill   <= '0;
            r_count  <= '0;
        end else begin
            r_window <= n_window;
            r_fill   <= n_fill;
            r_count  <= n_count;
        end
    end

    assign o_window_empty = (r_fill == '0);

endmodule

[rtl/ssr_cmd_queue.sv]
// Short command queue that decouples the front part from the back part.
module ssr_cmd_queue import ssr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_take
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_take;

    assign do_push = i_push && !o_full;
    assign do_take = i_take && o_valid;

    // Storage needs no reset; only the pointers and the count do.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_take) begin
                r_count <= r_count + 1'b1;
            end else if (do_take && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

[rtl/ssr_back.sv]
// Back part: walks commands one result per cycle to the output register if free.
module ssr_back import ssr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cmd_valid,
    input  t_cmd     i_cmd,
    input  t_window  i_repl_bytes,
    output logic     o_cmd_take,
    input  logic     i_pop,
    output logic     o_empty,
    output t_out_req o_data
);

    logic [LEN_W-1:0] r_idx;
    logic             r_out_valid;
    t_out_req         r_out;

    logic [LEN_W-1:0] n_idx;
    logic [LEN_W-1:0] res_cnt;
    logic [LEN_W-1:0] flush_off;
    logic             last_res;
    logic             slot_free;
    logic             produce;
    logic [7:0]       res_byte;
    t_out_req         res;

    // Select the byte for the current position in the command's result list.
    always_comb begin
        res_cnt   = (i_cmd.real_cnt == '0) ? LEN_W'(1) : i_cmd.real_cnt;
        last_res  = (r_idx == res_cnt - 1'b1);
        slot_free = !r_out_valid || i_pop;
        produce   = i_cmd_valid && slot_free;
        flush_off = r_idx - i_cmd.head_cnt;

        if (r_idx < i_cmd.head_cnt) begin
            res_byte = i_cmd.hit ? i_repl_bytes[r_idx[WIN_IDX_W-1:0]] : i_cmd.pop_byte;
        end else begin
            res_byte = i_cmd.flush[flush_off[WIN_IDX_W-1:0]];
        end

        res.char_valid  = (i_cmd.real_cnt != '0);
        res.char_out    = res.char_valid ? res_byte : 8'h00;
        res.string_done = i_cmd.last && last_res;
        res.match_total = res.string_done ? i_cmd.total : '0;

        n_idx = r_idx;
        if (produce) begin
            n_idx = last_res ? '0 : r_idx + 1'b1;
        end
    end

    // Output register: a new result enters when the slot is free or being drained.
    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd_take = produce && last_res;
    assign o_empty    = !r_out_valid;
    assign o_data     = r_out;

endmodule

[rtl/stream_substring_replace_top.sv]
// Top level of the streaming substring replacer: configuration registers and part wiring.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  ---------------------------------------------
//  input     push / full               i_data  : char_in, char_present, string_end
//  output    empty / pop               o_data  : char_out, char_valid, string_done,
//                                                match_total
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One input byte is accepted per cycle while the two-entry command queue has room.
// Each result leaves the back part at one per cycle while the output register is free or
// being popped; an item causes one result for a plain pass-through byte, and up to the
// replacement length on a match plus the window flush at end of string.
// Reset is synchronous and active low; it clears the window, the counters, the queue
// and the output valid flag, and restores the register defaults (pattern length one).
// A stalled output holds its result and fills the queue before full is raised.
module stream_substring_replace_top import ssr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_req               i_data,
    output logic                  empty,
    input  logic                  pop,
    output t_out_req              o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic window_empty;
    logic in_accept;
    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_valid;
    t_cmd cmd_out;
    logic cmd_take;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = push && !full;

    // Configuration registers; the pattern length only changes while the window is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_bytes      <= '0;
            r_cfg.pattern_length     <= LEN_W'(1);
            r_cfg.replacement_bytes  <= '0;
            r_cfg.replacement_length <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_BYTES: begin
                    r_cfg.pattern_bytes <= i_cfg_data;
                end
                CFG_PATTERN_LENGTH: begin
                    if (window_empty) begin
                        r_cfg.pattern_length <= i_cfg_data[LEN_W-1:0];
                    end
                end
                CFG_REPLACEMENT_BYTES: begin
                    r_cfg.replacement_bytes <= i_cfg_data;
                end
                CFG_REPLACEMENT_LENGTH: begin
                    r_cfg.replacement_length <= i_cfg_data[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    ssr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_req          (i_data),
        .i_cfg          (r_cfg),
        .o_cmd_push     (cmd_push),
        .o_cmd          (cmd_in),
        .o_window_empty (window_empty)
    );

    ssr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_out),
        .i_take  (cmd_take)
    );

    ssr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd_out),
        .i_repl_bytes (r_cfg.replacement_bytes),
        .o_cmd_take   (cmd_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_data       (o_data)
    );

endmodule

[rtl/ssr_checker.sv]
// Port-level checker for the streaming substring replacer, bound to the top level.
module ssr_checker import ssr_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     full,
    input logic     empty,
    input logic     pop,
    input t_out_req o_data
);

    // Leaving reset, no result is waiting and input is open.
    a_reset_state: assert property (@(posedge i_clk) $rose(i_rst_n) |-> empty && !full)
        else $error("queue state not clear after reset");

    // A result without a byte only ever closes a string and carries a zero byte.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_data.char_valid) |-> (o_data.string_done && o_data.char_out == 8'h00))
        else $error("byteless result that does not end a string");

    // The match count is shown only with the end of a string.
    a_total_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_data.string_done) |-> (o_data.match_total == '0))
        else $error("match count on a result that does not end a string");

    // A waiting result that is not taken stays unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data)))
        else $error("stalled result changed");

endmodule

bind stream_substring_replace_top ssr_checker u_ssr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_data  (o_data)
);

[tb/tb_top.sv]
// Self-checking testbench for the streaming substring replacer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ssr_pkg::*;

    localparam int SETTLE_CYCLES   = 8;
    localparam int END_CYCLES      = 24;
    localparam int RX_HOLD_CYCLES  = 150;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int IDLE_PCT        = 11;
    localparam int MAX_PRINTS      = 20;
    localparam int COUNT_CEILING   = 65535;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(CFG_REPLACEMENT_LENGTH) + 1'b1;

    // Block ports; the inputs are driven to known values from time zero.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  full;
    t_in_req               in_req    = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    t_out_req              out_res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Mirror of the register file, as it stands after reset.
    logic [63:0]      cfg_pattern     = '0;
    logic [LEN_W-1:0] cfg_pattern_len = LEN_W'(1);
    logic [63:0]      cfg_subst       = '0;
    logic [LEN_W-1:0] cfg_subst_len   = '0;

    // Mirror of the match window and the per-string match count.
    logic [7:0] win_bytes [MAX_PATTERN];
    int         win_fill    = 0;
    int         string_hits = 0;

    // Output characters predicted and not yet seen.
    t_out_req out_text_q[$];

    // Traffic control shared by the sender, the receiver and the tests.
    int tx_idle_pct = IDLE_PCT;
    int rx_idle_pct = IDLE_PCT;
    bit hold_rx     = 1'b0;

    // Run statistics.
    int errors       = 0;
    int reqs_sent    = 0;
    int results_seen = 0;
    int hits_total   = 0;
    int cfg_writes   = 0;
    int full_cycles  = 0;

    stream_substring_replace_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_data      (in_req),
        .empty       (empty),
        .pop         (pop),
        .o_data      (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Effective pattern length: zero acts as one, long values saturate.
    function automatic int pattern_span();
        if (cfg_pattern_len == '0) return 1;
        if (int'(cfg_pattern_len) > MAX_PATTERN) return MAX_PATTERN;
        return int'(cfg_pattern_len);
    endfunction

    function automatic t_out_req char_result(logic [7:0] ch);
        t_out_req r;
        r = '0;
        r.char_out   = ch;
        r.char_valid = 1'b1;
        return r;
    endfunction

    // Remove the oldest byte from the window mirror.
    function automatic logic [7:0] shift_window();
        logic [7:0] b;
        int         k;
        b = win_bytes[0];
        for (k = 1; k < MAX_PATTERN; k++) begin
            win_bytes[k-1] = win_bytes[k];
        end
        win_bytes[MAX_PATTERN-1] = 8'h00;
        if (win_fill > 0) win_fill--;
        return b;
    endfunction

    // Register write as seen by the block; the pattern length is locked while
    // the window holds any byte, and spare indexes are ignored.
    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
        case (idx)
            CFG_PATTERN_BYTES:      cfg_pattern = d;
            CFG_PATTERN_LENGTH:     if (win_fill == 0) cfg_pattern_len = d[LEN_W-1:0];
            CFG_REPLACEMENT_BYTES:  cfg_subst = d;
            CFG_REPLACEMENT_LENGTH: cfg_subst_len = d[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    // Predict the output characters caused by one accepted request.
    function automatic void rewrite_step(t_in_req it);
        t_out_req batch[$];
        t_out_req tail;
        int       span;
        int       subst_n;
        int       k;
        bit       hit;
        span    = pattern_span();
        subst_n = (int'(cfg_subst_len) > MAX_REPLACEMENT) ? MAX_REPLACEMENT
                                                          : int'(cfg_subst_len);
        if (it.char_present) begin
            if (win_fill < MAX_PATTERN) begin
                win_bytes[win_fill] = it.char_in;
                win_fill++;
            end
            if (win_fill >= span) begin
                hit = 1'b1;
                for (k = 0; k < span; k++) begin
                    if (win_bytes[k] != cfg_pattern[8*k +: 8]) hit = 1'b0;
                end
                if (hit) begin
                    for (k = 0; k < subst_n; k++) begin
                        batch.push_back(char_result(cfg_subst[8*k +: 8]));
                    end
                    for (k = 0; k < MAX_PATTERN; k++) begin
                        win_bytes[k] = 8'h00;
                    end
                    win_fill = 0;
                    hits_total++;
                    if (string_hits < COUNT_CEILING) string_hits++;
                end else begin
                    batch.push_back(char_result(shift_window()));
                end
            end
        end
        // End of string: flush the window and tag the last output with the count.
        if (it.string_end) begin
            while (win_fill > 0) begin
                batch.push_back(char_result(shift_window()));
            end
            if (batch.size() == 0) batch.push_back(t_out_req'('0));
            tail = batch.pop_back();
            tail.string_done = 1'b1;
            tail.match_total = CNT_W'(string_hits);
            batch.push_back(tail);
            string_hits = 0;
        end
        for (k = 0; k < batch.size(); k++) begin
            out_text_q.push_back(batch[k]);
        end
    endfunction

    function automatic t_in_req char_req(logic [7:0] ch, logic last);
        t_in_req r;
        r.char_in      = ch;
        r.char_present = 1'b1;
        r.string_end   = last;
        return r;
    endfunction

    // Request without a byte: a bare end marker, or an idle step when last is low.
    function automatic t_in_req marker_req(logic last);
        t_in_req r;
        r.char_in      = 8'($urandom_range(255));
        r.char_present = 1'b0;
        r.string_end   = last;
        return r;
    endfunction

    // Offer one request, with random idle cycles first, and predict its
    // outputs once it is taken. Push stays high for a following request.
    task automatic send_item(t_in_req it);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push   <= 1'b1;
        in_req <= it;
        @(posedge clk);
        while (full !== 1'b0) @(posedge clk);
        rewrite_step(it);
        reqs_sent++;
    endtask

    // Stop offering, wait for every predicted output and let the block settle.
    task automatic wait_drained();
        push <= 1'b0;
        while (out_text_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        apply_reg_write(idx, d);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [63:0] pat, logic [LEN_W-1:0] pat_len,
                             logic [63:0] subst, logic [LEN_W-1:0] subst_len);
        wait_drained();
        write_reg(CFG_PATTERN_BYTES, pat);
        write_reg(CFG_PATTERN_LENGTH, 64'(pat_len));
        write_reg(CFG_REPLACEMENT_BYTES, subst);
        write_reg(CFG_REPLACEMENT_LENGTH, 64'(subst_len));
    endtask

    // Random text built mostly from whole and partial copies of the pattern,
    // with stray bytes, idle steps and string ends mixed in. The last string
    // is always closed so the window is empty afterwards.
    task automatic run_text(int n_items);
        int         sent;
        int         pick;
        int         span;
        int         seg;
        int         k;
        logic [7:0] ch;
        sent = 0;
        while (sent < n_items) begin
            span = pattern_span();
            pick = $urandom_range(99);
            if (pick < 45) begin
                for (k = 0; k < span; k++) begin
                    send_item(char_req(cfg_pattern[8*k +: 8],
                                       (k == span - 1) && ($urandom_range(9) == 0)));
                    sent++;
                end
            end else if (pick < 60) begin
                seg = $urandom_range(span - 1);
                for (k = 0; k < seg; k++) begin
                    send_item(char_req(cfg_pattern[8*k +: 8], 1'b0));
                    sent++;
                end
            end else if (pick < 85) begin
                k  = $urandom_range(span - 1);
                ch = $urandom_range(1) ? cfg_pattern[8*k +: 8] : 8'($urandom_range(255));
                send_item(char_req(ch, 1'b0));
                sent++;
            end else if (pick < 90) begin
                send_item(marker_req(1'b0));
            end else if (pick < 96) begin
                send_item(char_req(8'($urandom_range(255)), 1'b1));
                sent++;
            end else begin
                send_item(marker_req(1'b1));
                sent++;
            end
        end
        send_item(marker_req(1'b1));
    endtask

    // Reset values: a one-byte pattern of zero with an empty replacement.
    task automatic test_reset_defaults();
        send_item(char_req(8'h00, 1'b0));
        send_item(char_req(8'h41, 1'b0));
        send_item(marker_req(1'b1));
    endtask

    // Over-long lengths saturate: an eight-byte all-ones pattern is replaced by eight zero bytes.
    task automatic test_length_extremes();
        int k;
        configure('1, '1, '0, '1);
        send_item(char_req(8'h00, 1'b0));
        for (k = 0; k < MAX_PATTERN; k++) begin
            send_item(char_req(8'hFF, k == MAX_PATTERN - 1));
        end
    endtask

    // A zero pattern length acts as one; matches are deleted.
    task automatic test_zero_pattern_length();
        configure(64'h5A, '0, '0, '0);
        send_item(char_req(8'h5A, 1'b0));
        send_item(char_req(8'h80, 1'b0));
        send_item(char_req(8'h5A, 1'b1));
    endtask

    // Length write while the window holds bytes, idle step, flush on a bare
    // end, flush on a byte end, and a write to a spare index.
    task automatic test_length_change_mid_window();
        configure(64'h7A7978, LEN_W'(3), 64'h4241, LEN_W'(2));
        send_item(char_req(8'h78, 1'b0));
        send_item(char_req(8'h79, 1'b0));
        wait_drained();
        write_reg(CFG_PATTERN_LENGTH, 64'd1);
        send_item(marker_req(1'b0));
        send_item(char_req(8'h7A, 1'b0));
        send_item(char_req(8'h78, 1'b0));
        send_item(char_req(8'h71, 1'b0));
        send_item(marker_req(1'b1));
        send_item(char_req(8'h61, 1'b1));
        wait_drained();
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_SPARE_FIRST), (1 << CFG_IDX_W) - 1)),
                  {$urandom, $urandom});
    endtask

    // One-byte pattern with the longest replacement: maximum expansion.
    task automatic test_random_expansion();
        configure({$urandom, $urandom}, LEN_W'(1), {$urandom, $urandom}, LEN_W'(MAX_REPLACEMENT));
        run_text(28);
    endtask

    // Longest pattern, matches deleted.
    task automatic test_random_long_pattern();
        configure({$urandom, $urandom}, LEN_W'(MAX_PATTERN), {$urandom, $urandom}, '0);
        run_text(28);
    endtask

    // Mid-size pattern with neither side idling.
    task automatic test_random_calm();
        configure({$urandom, $urandom}, LEN_W'($urandom_range(2, MAX_PATTERN - 1)),
                  {$urandom, $urandom}, LEN_W'($urandom_range(0, 15)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_text(28);
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    // Receiver holds off while requests keep coming, so the block fills up.
    task automatic test_backpressure();
        configure({$urandom, $urandom}, LEN_W'(MAX_PATTERN), '1, LEN_W'(3));
        hold_rx = 1'b1;
        run_text(28);
    endtask

    // Fully random settings, any length code included.
    task automatic test_random_mixed();
        int n;
        for (n = 0; n < 2; n++) begin
            configure({$urandom, $urandom}, LEN_W'($urandom_range(0, 15)),
                      {$urandom, $urandom}, LEN_W'($urandom_range(0, 15)));
            run_text(14);
        end
    endtask

    // Receiver: random pop stalls, plus one long hold-off on request.
    initial begin : receiver
        int n;
        forever begin
            @(posedge clk);
            if (hold_rx) begin
                hold_rx = 1'b0;
                pop <= 1'b0;
                for (n = 0; n < RX_HOLD_CYCLES; n++) @(posedge clk);
            end
            if (!rst_n) begin
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic report_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            if (errors <= MAX_PRINTS) begin
                $display("%0t ns: %s expected %0h, actual %0h", $time, name, want_v, got_v);
            end
        end
    endtask

    // Compare each output request taken with the oldest prediction.
    always @(posedge clk) begin : output_check
        t_out_req want;
        if (rst_n && pop && !empty) begin
            results_seen++;
            if (out_text_q.size() == 0) begin
                errors++;
                if (errors <= MAX_PRINTS) begin
                    $display("%0t ns: expected no output, actual char %0h valid %0b done %0b total %0d",
                             $time, out_res.char_out, out_res.char_valid,
                             out_res.string_done, out_res.match_total);
                end
            end else begin
                want = out_text_q.pop_front();
                report_field("char_out", 16'(want.char_out), 16'(out_res.char_out));
                report_field("char_valid", 16'(want.char_valid), 16'(out_res.char_valid));
                report_field("string_done", 16'(want.string_done), 16'(out_res.string_done));
                report_field("match_total", want.match_total, out_res.match_total);
            end
        end
    end

    always @(posedge clk) begin
        if (push && full) full_cycles++;
    end

    // Watchdog: ends the run when no handshake completes for too long.
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("tb_top: no handshake for %0d cycles, %0d outputs outstanding",
                 WATCHDOG_LIMIT, out_text_q.size());
        $display("tb_top: done, errors");
        $finish;
    end

    // Test sequence.
    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_length_extremes();
        test_zero_pattern_length();
        test_length_change_mid_window();
        test_random_expansion();
        test_random_long_pattern();
        test_random_calm();
        test_backpressure();
        test_random_mixed();
        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        $display("tb_top: %0d requests in, %0d outputs checked, %0d matches, %0d register writes",
                 reqs_sent, results_seen, hits_total, cfg_writes);
        $display("tb_top: input held off by full for %0d cycles", full_cycles);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/ssr_pkg.sv
rtl/ssr_front.sv
rtl/ssr_cmd_queue.sv
rtl/ssr_back.sv
rtl/stream_substring_replace_top.sv
rtl/ssr_checker.sv
tb/tb_top.sv
